### sv/dru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dru_pkg: shared types and constants of the bitmap row pixel unpacker
// Register indexes, source format codes and field widths.
// ----------------------------------------------------------------------------
package dru_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_ROW_PIXELS   = 2'd1;
   localparam logic [1:0] CSR_ROW_BYTES    = 2'd2;
   localparam logic [1:0] CSR_IMAGE_ROWS   = 2'd3;

   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 15;
   localparam int unsigned FORMAT_W    = 3;
   localparam int unsigned IMG_WIDTH_W = 13;
   localparam int unsigned ROW_BYTES_W = 15;
   localparam int unsigned IMG_ROWS_W  = 13;

   // source pixel formats
   localparam logic [2:0] FMT_1BPP  = 3'd0;
   localparam logic [2:0] FMT_4BPP  = 3'd1;
   localparam logic [2:0] FMT_8BPP  = 3'd2;
   localparam logic [2:0] FMT_24BPP = 3'd3;
   localparam logic [2:0] FMT_32BPP = 3'd4;

   // request kinds (req_tuser)
   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_DATA    = 1'b1;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned PIXEL_W    = 32;

   // how a held byte turns into pixel words
   typedef enum logic [1:0] {
      MODE_BIT    = 2'd0,   // 1 bpp: entries 0 and 1 chosen per bit
      MODE_NIBBLE = 2'd1,   // 4 bpp: high nibble entry, then low nibble entry
      MODE_BYTE   = 2'd2,   // 8 bpp: one entry
      MODE_DIRECT = 2'd3    // 24/32 bpp: assembled colour word
   } mode_type;

endpackage

### sv/dib_row_pixel_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dib_row_pixel_unpacker: bitmap row bytes to 32-bit pixel words
// Palette store, row/pixel/row-count tracking and a per-byte pixel emitter.
// ----------------------------------------------------------------------------
// A request beat is either a palette write (req_tuser = 0) or one source byte
// of a bitmap row (req_tuser = 1). Palette writes and bytes that make no pixel
// (colour bytes still being gathered, row padding, unknown format) do not load
// the emit stage. A byte that makes pixels is taken and held in a single emit
// stage that hands one pixel per cycle to the output register while rsp is not
// stalled: 8, 24 and 32 bpp thus sustain one byte per cycle, while a 4 bpp byte
// is held for up to 2 pixels and a 1 bpp byte for up to 8. The next byte is
// taken in the cycle the last pixel of the held byte moves out, so pixel-making
// bytes back to back leave no gap in the pixel stream. A byte's first pixel
// reaches rsp through the palette read registers, then the output register.
// The palette is a synchronous memory with two read ports, both read in the
// beat's cycle; per-entry valid bits, cleared by reset, make never-written
// entries read as zero, so no clearing pass follows reset. The user must write
// configuration through csr_* while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module dib_row_pixel_unpacker #(
   parameter int unsigned MAX_WIDTH     = 4096,
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] palette_index, [39:8] palette_word, [47:40] data_byte
   input  logic [dru_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] req_type
   input  logic                              req_tuser,
   // pixel stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] pixel_word
   output logic [dru_pkg::PIXEL_W-1:0]       rsp_tdata,
   // last_of_run
   output logic                              rsp_tlast,
   // [0] end_of_row, [1] end_of_image
   output logic [1:0]                        rsp_tuser,
   // configuration writes
   input  logic                              csr_we,
   input  logic [dru_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dru_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned AW = $clog2(PALETTE_DEPTH);
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);          // pixel count
   localparam int unsigned CW = (WW > 13) ? WW : 13;            // width compare
   localparam int unsigned RBW = dru_pkg::ROW_BYTES_W;
   localparam int unsigned RCW = dru_pkg::IMG_ROWS_W;
   localparam logic [2:0] LAST_BIT = 3'd7;

   // ---------------- configuration ----------------
   logic [dru_pkg::FORMAT_W-1:0]    pixel_format_ff;
   logic [dru_pkg::IMG_WIDTH_W-1:0] row_pixels_ff;
   logic [dru_pkg::ROW_BYTES_W-1:0] row_bytes_ff;
   logic [dru_pkg::IMG_ROWS_W-1:0]  image_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= dru_pkg::FMT_8BPP;
         row_pixels_ff   <= 13'd1;
         row_bytes_ff    <= 15'd4;
         image_rows_ff   <= 13'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            dru_pkg::CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[2:0];
            dru_pkg::CSR_ROW_PIXELS:   row_pixels_ff   <= csr_wdata[12:0];
            dru_pkg::CSR_ROW_BYTES:    row_bytes_ff    <= csr_wdata[14:0];
            dru_pkg::CSR_IMAGE_ROWS:   image_rows_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // ---------------- request fields ----------------
   logic [7:0]  req_pal_index;
   logic [31:0] req_pal_word;
   logic [7:0]  req_byte;
   logic        req_fire;
   logic        pal_write;
   logic        data_beat;

   assign req_pal_index = req_tdata[7:0];
   assign req_pal_word  = req_tdata[39:8];
   assign req_byte      = req_tdata[47:40];
   assign req_fire      = req_tvalid && req_tready;
   assign pal_write     = req_fire && (req_tuser == dru_pkg::REQ_PALETTE);
   assign data_beat     = req_fire && (req_tuser == dru_pkg::REQ_DATA);

   // ---------------- row state ----------------
   logic [RBW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [WW-1:0]  pix_cnt_ff,  pix_cnt_in;
   logic [RCW-1:0] row_cnt_ff,  row_cnt_in;
   logic [23:0]    asm_ff,      asm_in;
   logic [1:0]     phase_ff,    phase_in;

   logic [WW-1:0]  width_eff;
   logic [WW-1:0]  remain;
   logic           active;
   logic           last_row;
   logic           row_done;
   logic [3:0]     n_pix;
   dru_pkg::mode_type mode;
   logic [31:0]    direct_word;
   logic [7:0]     idx_a, idx_b;
   logic           eor_hit;

   always_comb begin
      if (CW'(row_pixels_ff) > CW'(MAX_WIDTH))
         width_eff = WW'(MAX_WIDTH);
      else
         width_eff = WW'(row_pixels_ff);
      active   = pix_cnt_ff < width_eff;
      remain   = width_eff - pix_cnt_ff;
      last_row = ({1'b0, row_cnt_ff} + 14'd1) >= {1'b0, image_rows_ff};
      row_done = ({1'b0, byte_cnt_ff} + 16'd1) >= {1'b0, row_bytes_ff};

      n_pix       = 4'd0;
      mode        = dru_pkg::MODE_BYTE;
      direct_word = {8'h00, req_byte, asm_ff[15:0]};
      idx_a       = req_byte;
      idx_b       = req_byte;
      asm_in      = asm_ff;
      phase_in    = phase_ff;

      if (active) begin
         unique case (pixel_format_ff)
            dru_pkg::FMT_1BPP: begin
               mode  = dru_pkg::MODE_BIT;
               idx_a = 8'h00;
               idx_b = 8'h01;
               n_pix = (remain >= WW'(8)) ? 4'd8 : remain[3:0];
            end
            dru_pkg::FMT_4BPP: begin
               mode  = dru_pkg::MODE_NIBBLE;
               idx_a = {4'h0, req_byte[7:4]};
               idx_b = {4'h0, req_byte[3:0]};
               n_pix = (remain > WW'(1)) ? 4'd2 : 4'd1;
            end
            dru_pkg::FMT_8BPP: begin
               mode  = dru_pkg::MODE_BYTE;
               n_pix = 4'd1;
            end
            dru_pkg::FMT_24BPP: begin
               mode = dru_pkg::MODE_DIRECT;
               // top byte forced to zero
               direct_word = {8'h00, req_byte, asm_ff[15:0]};
               if (phase_ff >= 2'd2) begin
                  n_pix    = 4'd1;
                  phase_in = 2'd0;
                  asm_in   = 24'd0;
               end else begin
                  asm_in   = asm_ff | (24'(req_byte) << {phase_ff, 3'b000});
                  phase_in = phase_ff + 2'd1;
               end
            end
            dru_pkg::FMT_32BPP: begin
               mode = dru_pkg::MODE_DIRECT;
               direct_word = {req_byte, asm_ff};
               if (phase_ff == 2'd3) begin
                  n_pix    = 4'd1;
                  phase_in = 2'd0;
                  asm_in   = 24'd0;
               end else begin
                  asm_in   = asm_ff | (24'(req_byte) << {phase_ff, 3'b000});
                  phase_in = phase_ff + 2'd1;
               end
            end
            default: ;   // unknown format: byte only counted
         endcase
      end

      pix_cnt_in = pix_cnt_ff + WW'(n_pix);
      eor_hit    = (pix_cnt_in == width_eff);

      byte_cnt_in = byte_cnt_ff + RBW'(1);
      row_cnt_in  = row_cnt_ff;
      if (row_done) begin
         byte_cnt_in = '0;
         pix_cnt_in  = '0;
         phase_in    = 2'd0;
         asm_in      = 24'd0;
         row_cnt_in  = last_row ? '0 : row_cnt_ff + RCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         pix_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         asm_ff      <= '0;
         phase_ff    <= '0;
      end else if (data_beat) begin
         byte_cnt_ff <= byte_cnt_in;
         pix_cnt_ff  <= pix_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         asm_ff      <= asm_in;
         phase_ff    <= phase_in;
      end
   end

   // ---------------- palette store ----------------
   logic [31:0]              pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_vld_ff;
   logic                     wr_in_range;
   logic                     a_in_range, b_in_range;
   logic                     s1_load;

   assign wr_in_range = {1'b0, req_pal_index} < 9'(PALETTE_DEPTH);
   assign a_in_range  = {1'b0, idx_a} < 9'(PALETTE_DEPTH);
   assign b_in_range  = {1'b0, idx_b} < 9'(PALETTE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset)
         pal_vld_ff <= '0;
      else if (pal_write && wr_in_range)
         pal_vld_ff[req_pal_index[AW-1:0]] <= 1'b1;
   end

   // registered reads, both ports taken with the byte
   logic [31:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (pal_write && wr_in_range)
         pal_mem[req_pal_index[AW-1:0]] <= req_pal_word;
      if (s1_load) begin
         rd_a_ff <= pal_mem[idx_a[AW-1:0]];
         rd_b_ff <= pal_mem[idx_b[AW-1:0]];
      end
   end

   // ---------------- emit stage ----------------
   logic              s1_vld_ff;
   logic [2:0]        k_ff;
   logic [3:0]        s1_n_ff;
   dru_pkg::mode_type s1_mode_ff;
   logic [7:0]        s1_byte_ff;
   logic [31:0]       s1_direct_ff;
   logic              s1_ok_a_ff, s1_ok_b_ff;
   logic              s1_eor_ff, s1_eoi_ff;

   logic        out_free;
   logic        emit;
   logic        emit_last;
   logic [31:0] emit_word;
   logic [31:0] word_a, word_b;

   assign out_free  = !rsp_tvalid || rsp_tready;
   assign emit      = s1_vld_ff && out_free;
   assign emit_last = emit && ({1'b0, k_ff} == (s1_n_ff - 4'd1));
   assign req_tready = !s1_vld_ff || emit_last;
   assign s1_load   = data_beat && (n_pix != 4'd0);

   assign word_a = s1_ok_a_ff ? rd_a_ff : 32'd0;
   assign word_b = s1_ok_b_ff ? rd_b_ff : 32'd0;

   always_comb begin
      unique case (s1_mode_ff)
         dru_pkg::MODE_BIT:    emit_word = s1_byte_ff[LAST_BIT - k_ff] ? word_b : word_a;
         dru_pkg::MODE_NIBBLE: emit_word = (k_ff == 3'd0) ? word_a : word_b;
         dru_pkg::MODE_BYTE:   emit_word = word_a;
         dru_pkg::MODE_DIRECT: emit_word = s1_direct_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         k_ff      <= '0;
      end else begin
         if (s1_load) begin
            s1_vld_ff <= 1'b1;
            k_ff      <= '0;
         end else if (emit_last) begin
            s1_vld_ff <= 1'b0;
         end else if (emit) begin
            k_ff <= k_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_n_ff      <= n_pix;
         s1_mode_ff   <= mode;
         s1_byte_ff   <= req_byte;
         s1_direct_ff <= direct_word;
         s1_ok_a_ff   <= a_in_range && pal_vld_ff[idx_a[AW-1:0]];
         s1_ok_b_ff   <= b_in_range && pal_vld_ff[idx_b[AW-1:0]];
         s1_eor_ff    <= eor_hit;
         s1_eoi_ff    <= eor_hit && last_row;
      end
   end

   // ---------------- output register ----------------
   logic        rsp_vld_ff;
   logic [31:0] rsp_word_ff;
   logic        rsp_last_ff, rsp_eor_ff, rsp_eoi_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_vld_ff <= 1'b0;
      else if (out_free)
         rsp_vld_ff <= emit;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= emit_word;
         rsp_last_ff <= emit_last;
         rsp_eor_ff  <= emit_last && s1_eor_ff;   // flag only on final pixel of byte
         rsp_eoi_ff  <= emit_last && s1_eoi_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_eoi_ff, rsp_eor_ff};

endmodule
